// ===== src/tos_pkg.sv =====
// Package for the typed operand stack: sizing constants, operation, type and status codes,
// the transfer structs of both channels and the type size helpers.
// Depends on nothing; every file of the block imports it.
`timescale 1ns / 1ps

package tos_pkg;

    localparam int STACK_BYTES   = 1024;
    localparam int POINTER_BYTES = 8;
    localparam int NATIVE_BYTES  = 4;
    localparam int MAX_ENTRIES   = 256;

    // Field widths of the transfers.
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 64;
    localparam int TAG_W    = 3;
    localparam int POS_W    = 9;
    localparam int DEPTH_W  = 9;
    localparam int USED_W   = 11;
    localparam int STATUS_W = 2;

    // Internal widths, most of them derived from the sizing constants.
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int BYTES_W     = $clog2(STACK_BYTES + 1);
    localparam int START_W     = $clog2(STACK_BYTES);
    localparam int BYTES_SUM_W = BYTES_W + 1;
    localparam int CMP_W       = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;
    localparam int SIZE_W      = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SHRINK = 3'd3,
        OP_DUP    = 3'd4
    } op_code_t;

    typedef enum logic [TAG_W-1:0] {
        TAG_INT32     = 3'd0,
        TAG_INT64     = 3'd1,
        TAG_NATIVE    = 3'd2,
        TAG_POINTER   = 3'd3,
        TAG_VALUETYPE = 3'd4,
        TAG_ARRAY     = 3'd5,
        TAG_FLOAT32   = 3'd6,
        TAG_FLOAT64   = 3'd7
    } tag_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } fsm_state_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] push_value;
        logic [TAG_W-1:0]   push_type;
        logic [POS_W-1:0]   position;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [TAG_W-1:0]    read_type;
        logic [TAG_W-1:0]    top_tag;
        logic                top_is_float;
        logic                top_is_integer;
        logic [DEPTH_W-1:0]  depth;
        logic [USED_W-1:0]   bytes_used;
        logic                is_full;
        logic                is_empty;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Bytes of the budget that one entry of the given type occupies.
    function automatic logic [SIZE_W-1:0] tag_size(input logic [TAG_W-1:0] tag);
        logic [SIZE_W-1:0] size;
        unique case (tag)
            TAG_INT32:     size = SIZE_W'(4);
            TAG_INT64:     size = SIZE_W'(8);
            TAG_NATIVE:    size = SIZE_W'(NATIVE_BYTES);
            TAG_POINTER,
            TAG_VALUETYPE,
            TAG_ARRAY:     size = SIZE_W'(POINTER_BYTES);
            TAG_FLOAT32:   size = SIZE_W'(4);
            default:       size = SIZE_W'(8);
        endcase
        return size;
    endfunction

    // Types of four bytes keep only the low word of the value.
    function automatic logic [VALUE_W-1:0] fit_value(input logic [VALUE_W-1:0] value,
                                                     input logic [TAG_W-1:0] tag);
        logic [VALUE_W-1:0] fitted;
        if (tag_size(tag) <= SIZE_W'(4))
            fitted = {32'd0, value[31:0]};
        else
            fitted = value;
        return fitted;
    endfunction

endpackage

// ===== src/typed_operand_stack_unit.sv =====
// Top level of the typed operand stack: entry memories, the two-step sequencer and the
// result register. Depends on tos_pkg for constants, codes, transfer structs and helpers.
`timescale 1ns / 1ps

// Evaluation stack for a bytecode runtime. Each command transfer (push, pop, peek, shrink
// or duplicate top) produces exactly one response transfer that carries the value and type
// read, the type of the new top, its float and integer class, the depth, the bytes in use,
// the full and empty flags and a status. In the cycle a command is transferred the entry
// memories are read; in the next cycle the result is computed, and once the response
// register has room a pushed entry is written back and the response register is loaded.
// A new command is taken only after the last one has committed; a stalled response holds
// the block in its second step until the response register frees. Errors never change
// the stack: a push or duplicate that would exceed the byte budget or the entry limit
// reports overflow, a pop or duplicate on an empty stack reports underflow, and a peek or
// shrink position beyond the depth reports a range error. Unknown operation codes change
// nothing and report ok. Entries that were never written are never read for a result, so
// the memories need no clearing after reset and the block is ready as soon as reset is
// released.
module typed_operand_stack_unit
    import tos_pkg::*;
(
    input  logic clk,
    input  logic rst_n,

    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,

    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Entry memories, all indexed by the entry number.
    logic [VALUE_W-1:0] value_mem [MAX_ENTRIES];
    logic [TAG_W-1:0]   tag_mem   [MAX_ENTRIES];
    logic [START_W-1:0] start_mem [MAX_ENTRIES];

    fsm_state_t state_reg, state_next;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [TAG_W-1:0]   top_reg, top_next;

    cmd_t cmd_reg;

    // Registered read data of the memories.
    logic [VALUE_W-1:0] rd_value_reg;
    logic [TAG_W-1:0]   rd_tag_a_reg;
    logic [TAG_W-1:0]   rd_tag_b_reg;
    logic [START_W-1:0] rd_start_reg;

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic cmd_fire;
    logic exec_fire;

    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;

    logic               wr_en;
    logic [VALUE_W-1:0] wr_value;
    logic [TAG_W-1:0]   wr_tag;
    logic [VALUE_W-1:0] read_value;
    logic [TAG_W-1:0]   read_type;
    status_t            status;
    rsp_t               rsp_next;

    //--------------------------------------------------------------------------------------
    // Sequencer. A command is taken only in IDLE; EXEC waits for room in the response
    // register before it commits.
    //--------------------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_stall = 1'b1;
        exec_fire = 1'b0;
        unique case (state_reg)
            S_IDLE:  cmd_stall = 1'b0;
            S_EXEC:  exec_fire = !rsp_valid_reg || !rsp_stall;
            default: cmd_stall = 1'b1;
        endcase
    end

    assign cmd_fire = cmd_valid && !cmd_stall;

    //--------------------------------------------------------------------------------------
    // Read addresses, formed from the incoming command and the current depth. Port A
    // reads the entry the operation works on; port B reads the type of the entry that
    // becomes the top after a pop or a shrink.
    //--------------------------------------------------------------------------------------
    always_comb
    begin
        logic [CMP_W-1:0] cnt_c;
        logic [CMP_W-1:0] pos_c;
        logic [CMP_W-1:0] a_c;
        logic [CMP_W-1:0] b_c;
        cnt_c = CMP_W'(count_reg);
        pos_c = CMP_W'(cmd.position);
        unique case (cmd.operation)
            OP_PEEK:
            begin
                a_c = cnt_c - pos_c - CMP_W'(1);
                b_c = cnt_c - CMP_W'(2);
            end
            OP_SHRINK:
            begin
                a_c = pos_c;
                b_c = pos_c - CMP_W'(1);
            end
            default:
            begin
                a_c = cnt_c - CMP_W'(1);
                b_c = cnt_c - CMP_W'(2);
            end
        endcase
        addr_a = a_c[ADDR_W-1:0];
        addr_b = b_c[ADDR_W-1:0];
    end

    // Memory reads happen only at a command transfer, so the read data holds while the
    // response side stalls. Writes land at the end of EXEC, before the next read.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            rd_value_reg <= value_mem[addr_a];
            rd_tag_a_reg <= tag_mem[addr_a];
            rd_tag_b_reg <= tag_mem[addr_b];
            rd_start_reg <= start_mem[addr_a];
        end
        if (exec_fire && wr_en)
        begin
            value_mem[count_reg[ADDR_W-1:0]] <= wr_value;
            tag_mem[count_reg[ADDR_W-1:0]]   <= wr_tag;
            start_mem[count_reg[ADDR_W-1:0]] <= bytes_reg[START_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            cmd_reg <= cmd;
    end

    //--------------------------------------------------------------------------------------
    // Execution of the registered command against the read data.
    //--------------------------------------------------------------------------------------
    always_comb
    begin
        logic [SIZE_W-1:0]      new_size;
        logic [BYTES_SUM_W-1:0] bytes_sum;
        logic                   room_ok;
        logic [CMP_W-1:0]       cnt_c;
        logic [CMP_W-1:0]       pos_c;
        logic                   is_push;

        is_push   = (cmd_reg.operation == OP_PUSH);
        new_size  = is_push ? tag_size(cmd_reg.push_type) : tag_size(rd_tag_a_reg);
        bytes_sum = BYTES_SUM_W'(bytes_reg) + BYTES_SUM_W'(new_size);
        room_ok   = (count_reg < COUNT_W'(MAX_ENTRIES))
                 && (bytes_sum <= BYTES_SUM_W'(STACK_BYTES));
        cnt_c     = CMP_W'(count_reg);
        pos_c     = CMP_W'(cmd_reg.position);

        count_next = count_reg;
        bytes_next = bytes_reg;
        top_next   = top_reg;
        status     = STAT_OK;
        read_value = '0;
        read_type  = '0;
        wr_en      = 1'b0;
        wr_value   = is_push ? fit_value(cmd_reg.push_value, cmd_reg.push_type)
                             : rd_value_reg;
        wr_tag     = is_push ? cmd_reg.push_type : rd_tag_a_reg;

        unique case (cmd_reg.operation)
            OP_PUSH:
            begin
                if (room_ok)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    bytes_next = bytes_sum[BYTES_W-1:0];
                    top_next   = cmd_reg.push_type;
                end
                else
                    status = STAT_OVERFLOW;
            end
            OP_POP:
            begin
                if (count_reg == '0)
                    status = STAT_UNDERFLOW;
                else
                begin
                    read_value = rd_value_reg;
                    read_type  = rd_tag_a_reg;
                    count_next = count_reg - COUNT_W'(1);
                    bytes_next = BYTES_W'(rd_start_reg);
                    top_next   = (count_reg > COUNT_W'(1)) ? rd_tag_b_reg : TAG_INT32;
                end
            end
            OP_PEEK:
            begin
                if (pos_c >= cnt_c)
                    status = STAT_RANGE;
                else
                begin
                    read_value = rd_value_reg;
                    read_type  = rd_tag_a_reg;
                end
            end
            OP_SHRINK:
            begin
                if (pos_c > cnt_c)
                    status = STAT_RANGE;
                else if (pos_c < cnt_c)
                begin
                    count_next = COUNT_W'(cmd_reg.position);
                    bytes_next = BYTES_W'(rd_start_reg);
                    top_next   = (cmd_reg.position != '0) ? rd_tag_b_reg : TAG_INT32;
                end
            end
            OP_DUP:
            begin
                // The copy keeps the tag of the top entry, pointer classes included.
                if (count_reg == '0)
                    status = STAT_UNDERFLOW;
                else if (room_ok)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    bytes_next = bytes_sum[BYTES_W-1:0];
                end
                else
                    status = STAT_OVERFLOW;
            end
            default:
            begin
                status = STAT_OK;
            end
        endcase

        rsp_next.read_value     = read_value;
        rsp_next.read_type      = read_type;
        rsp_next.top_tag        = top_next;
        rsp_next.top_is_float   = (count_next != '0)
                               && (top_next == TAG_FLOAT32 || top_next == TAG_FLOAT64);
        rsp_next.top_is_integer = (count_next != '0)
                               && (top_next == TAG_INT32 || top_next == TAG_INT64
                                   || top_next == TAG_NATIVE);
        rsp_next.depth          = DEPTH_W'(count_next);
        rsp_next.bytes_used     = USED_W'(bytes_next);
        rsp_next.is_full        = (BYTES_SUM_W'(bytes_next) + BYTES_SUM_W'(1))
                               >= BYTES_SUM_W'(STACK_BYTES);
        rsp_next.is_empty       = (bytes_next == '0);
        rsp_next.status         = status;
    end

    //--------------------------------------------------------------------------------------
    // Control state and the response register.
    //--------------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            bytes_reg     <= '0;
            top_reg       <= TAG_INT32;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                count_reg     <= count_next;
                bytes_reg     <= bytes_next;
                top_reg       <= top_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    //--------------------------------------------------------------------------------------
    // Assertions.
    //--------------------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_ENTRIES))
        else $error("entry count beyond the entry limit");

    a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= BYTES_W'(STACK_BYTES))
        else $error("bytes in use beyond the byte budget");

    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (bytes_reg == '0))
        else $error("entry count and bytes in use disagree on an empty stack");

    a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && status != STAT_OK) |=> ($stable(count_reg) && $stable(bytes_reg)))
        else $error("an operation with an error status changed the stack");

    a_exec_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> (state_reg == S_IDLE && rsp_valid_reg))
        else $error("committed command did not return to idle with a response");

endmodule
